>>> hw/rtl/generational_handle_table_macros.svh
// assertion macros for the handle table
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define GHT_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("handle table check failed");
`define GHT_ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("handle table sequencing check failed");
`else
`define GHT_ASSERT(lbl, clk, rst_n, expr)
`define GHT_ASSERT_NEXT(lbl, clk, rst_n, cause, effect)
`endif

`endif

>>> hw/rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

    localparam int TYPE_W      = 4;
    localparam int GEN_W       = 12;
    localparam int HDR_W       = TYPE_W + GEN_W;
    localparam int IDX_FIELD_W = 16;
    localparam int IDX_CMP_W   = IDX_FIELD_W + 1;
    localparam int HANDLE_W    = 32;
    localparam int PAYLOAD_W   = 64;

    localparam logic [TYPE_W-1:0] TYPE_FREED = 4'hF;
    localparam logic [TYPE_W-1:0] TYPE_LIMIT = 4'd8;
    localparam logic [TYPE_W-1:0] TYPE_MAX   = 4'hF;

    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_TYPE = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_BAD  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXE  = 2'b10
    } state_t;

endpackage

>>> hw/rtl/generational_handle_table.sv
// generational handle table: put, get and remove of 32-bit handles over SLOTS slots
// an accepted item is handled as a slot memory read, then an update that registers the result
// a new item is accepted only after the previous item's update, because of the registered read of the slot memories
// a held result stalls the update cycle until it is taken
// reset: asynchronous active low, free list starts at slot 0 with no clearing pass
`timescale 1ns / 1ps

`include "generational_handle_table_macros.svh"

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // handle_type[3:0], payload_in[67:4], handle_in[99:68], zeros
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // handle_out[31:0], payload_out[95:32]
    output logic [1:0]   m_tuser    // status[1:0]
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = IDX_W + 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] LINK_LAST = LINK_W'(SLOTS - 1);

    state_t              state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   fresh_reg, fresh_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [95:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic [1:0]          mode_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic                in_fire;
    logic                exe_go;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                hdr_we, pay_we, link_we;
    logic [HDR_W-1:0]    hdr_wdata;
    logic [LINK_W-1:0]   link_wdata;
    logic [HDR_W-1:0]    rd_hdr;
    logic [PAYLOAD_W-1:0] rd_pay;
    logic [LINK_W-1:0]   rd_link;

    logic                is_fresh;
    logic [HDR_W-1:0]    old_hdr;
    logic [GEN_W-1:0]    gen_inc;
    logic [GEN_W-1:0]    new_gen;
    logic [LINK_W-1:0]   next_link;
    logic [IDX_FIELD_W-1:0] h_idx;
    logic                h_hit;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [PAYLOAD_W-1:0] payload_out;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign exe_go   = (state_reg == S_EXE) && (!m_tvalid_reg || m_tready);

    // read address comes from the arriving item's handle, or from the free-list head for a put
    assign rd_addr = (s_tuser == MODE_PUT) ? head_reg[IDX_W-1:0] : s_tdata[68 +: IDX_W];

    ght_ram #(.WIDTH(HDR_W), .DEPTH(SLOTS)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (wr_addr),
        .wdata (hdr_wdata),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (rd_hdr)
    );

    ght_ram #(.WIDTH(PAYLOAD_W), .DEPTH(SLOTS)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (wr_addr),
        .wdata (payload_reg),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (rd_pay)
    );

    ght_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (wr_addr),
        .wdata (link_wdata),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (rd_link)
    );

    // slots at or above the fill count were never written
    assign is_fresh  = (head_reg == fresh_reg);
    assign old_hdr   = is_fresh ? ((head_reg == LINK_LAST) ? HDR_W'(0) : HDR_W'(1)) : rd_hdr;
    assign gen_inc   = old_hdr[GEN_W-1:0] + GEN_W'(1);
    assign new_gen   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
    assign next_link = is_fresh ? (head_reg + LINK_W'(1)) : rd_link;
    assign h_idx     = handle_reg[IDX_FIELD_W-1:0];
    assign h_hit     = ({1'b0, h_idx} < IDX_CMP_W'(fresh_reg))
                    && (rd_hdr == {type_reg, handle_reg[IDX_FIELD_W +: GEN_W]});

    always_comb
    begin
        status      = STATUS_BAD;
        handle_out  = '0;
        payload_out = '0;
        hdr_we      = 1'b0;
        pay_we      = 1'b0;
        link_we     = 1'b0;
        hdr_wdata   = {type_reg, new_gen};
        link_wdata  = head_reg;
        wr_addr     = h_idx[IDX_W-1:0];
        head_next   = head_reg;
        fresh_next  = fresh_reg;
        case (mode_reg)
            MODE_PUT:
            begin
                wr_addr = head_reg[IDX_W-1:0];
                if (type_reg inside {[TYPE_LIMIT:TYPE_MAX]})
                begin
                    status = STATUS_TYPE;
                end
                else if (head_reg == LINK_NULL)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    status     = STATUS_OK;
                    handle_out = {type_reg, new_gen, IDX_FIELD_W'(head_reg[IDX_W-1:0])};
                    hdr_we     = exe_go;
                    pay_we     = exe_go;
                    head_next  = next_link;
                    fresh_next = is_fresh ? (fresh_reg + LINK_W'(1)) : fresh_reg;
                end
            end
            MODE_GET, MODE_REMOVE:
            begin
                if (type_reg inside {[TYPE_LIMIT:TYPE_MAX]})
                begin
                    status = STATUS_TYPE;
                end
                else if (h_hit)
                begin
                    status      = STATUS_OK;
                    payload_out = rd_pay;
                    if (mode_reg == MODE_REMOVE)
                    begin
                        hdr_wdata = {TYPE_FREED, rd_hdr[GEN_W-1:0]};
                        hdr_we    = exe_go;
                        link_we   = exe_go;
                        head_next = LINK_W'(h_idx[IDX_W-1:0]);
                    end
                end
            end
            default:
            begin
                status = STATUS_BAD;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXE;
                end
            end
            S_EXE:
            begin
                if (exe_go)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            fresh_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exe_go)
            begin
                head_reg  <= head_next;
                fresh_reg <= fresh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= s_tuser;
            type_reg    <= s_tdata[3:0];
            payload_reg <= s_tdata[67:4];
            handle_reg  <= s_tdata[99:68];
        end
        if (exe_go)
        begin
            m_tuser_reg <= status;
            m_tdata_reg <= {payload_out, handle_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `GHT_ASSERT_NEXT(a_accept_to_exe, clk, rst_n, in_fire, state_reg == S_EXE)
    `GHT_ASSERT_NEXT(a_exe_gives_item, clk, rst_n, exe_go, m_tvalid_reg && (state_reg == S_IDLE))
    `GHT_ASSERT(a_head_below_fill, clk, rst_n, (head_reg <= fresh_reg) && (fresh_reg <= LINK_NULL))

endmodule

>>> hw/rtl/ght_ram.sv
`timescale 1ns / 1ps

module ght_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
